// ----- hdl/bis_pkg.sv -----
package bis_pkg;

    localparam int NUM_STEPS = 8;
    localparam int STEP_W    = 3;
    localparam int OP_W      = 3;
    localparam int LEVEL_W   = 8;
    localparam int TICKS_W   = 24;
    localparam int PHASE_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    // Operation codes of an input beat.
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
    localparam logic [OP_W-1:0] OP_SELECT = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_FAN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_FAN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_PUMP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREHEAT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIMING      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_GLOW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN     = 3'd6;

    // Reported phase codes.
    localparam logic [PHASE_W-1:0] CODE_OFF      = 3'd0;
    localparam logic [PHASE_W-1:0] CODE_PREHEAT  = 3'd1;
    localparam logic [PHASE_W-1:0] CODE_PRIMING  = 3'd2;
    localparam logic [PHASE_W-1:0] CODE_RUNNING  = 3'd3;
    localparam logic [PHASE_W-1:0] CODE_STOPGLOW = 3'd4;
    localparam logic [PHASE_W-1:0] CODE_COOLING  = 3'd5;

    typedef enum logic [5:0] {
        PH_OFF      = 6'b000001,
        PH_PREHEAT  = 6'b000010,
        PH_PRIMING  = 6'b000100,
        PH_RUNNING  = 6'b001000,
        PH_STOPGLOW = 6'b010000,
        PH_COOLING  = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [LEVEL_W-1:0] ignite_fan_level;
        logic [LEVEL_W-1:0] shutdown_fan_level;
        logic [LEVEL_W-1:0] startup_pump_rate;
        logic [TICKS_W-1:0] preheat_ticks;
        logic [TICKS_W-1:0] priming_ticks;
        logic [TICKS_W-1:0] stop_glow_ticks;
        logic [TICKS_W-1:0] cooldown_ticks;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [STEP_W-1:0]  step_index;
        logic [LEVEL_W-1:0] entry_fan_power;
        logic [LEVEL_W-1:0] entry_pump_rate;
    } t_item;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               fan_running;
        logic [LEVEL_W-1:0] fan_level;
        logic               pump_running;
        logic [LEVEL_W-1:0] pump_rate;
        logic               glow_plug_lit;
        logic [STEP_W-1:0]  current_step;
    } t_status;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_PREHEAT:  code = CODE_PREHEAT;
            PH_PRIMING:  code = CODE_PRIMING;
            PH_RUNNING:  code = CODE_RUNNING;
            PH_STOPGLOW: code = CODE_STOPGLOW;
            PH_COOLING:  code = CODE_COOLING;
            default:     code = CODE_OFF;
        endcase
        return code;
    endfunction

    // A duration of zero runs for one tick.
    function automatic logic [TICKS_W-1:0] timer_load(input logic [TICKS_W-1:0] ticks);
        return (ticks == '0) ? TICKS_W'(1) : ticks;
    endfunction

    function automatic logic step_ok(input logic [STEP_W-1:0] idx);
        return (int'(idx) < NUM_STEPS);
    endfunction

endpackage

// ----- hdl/bis_cfg_regs.sv -----
module bis_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output bis_pkg::t_cfg                      o_cfg
);

    bis_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ignite_fan_level   <= bis_pkg::LEVEL_W'(100);
            r_cfg.shutdown_fan_level <= bis_pkg::LEVEL_W'(100);
            r_cfg.startup_pump_rate  <= bis_pkg::LEVEL_W'(20);
            r_cfg.preheat_ticks      <= bis_pkg::TICKS_W'(60000);
            r_cfg.priming_ticks      <= bis_pkg::TICKS_W'(20000);
            r_cfg.stop_glow_ticks    <= bis_pkg::TICKS_W'(30000);
            r_cfg.cooldown_ticks     <= bis_pkg::TICKS_W'(60000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bis_pkg::CFG_STARTUP_FAN:
                    r_cfg.ignite_fan_level <= i_cfg_data[bis_pkg::LEVEL_W-1:0];
                bis_pkg::CFG_STOP_FAN:
                    r_cfg.shutdown_fan_level <= i_cfg_data[bis_pkg::LEVEL_W-1:0];
                bis_pkg::CFG_STARTUP_PUMP:
                    r_cfg.startup_pump_rate <= i_cfg_data[bis_pkg::LEVEL_W-1:0];
                bis_pkg::CFG_PREHEAT:
                    r_cfg.preheat_ticks <= i_cfg_data[bis_pkg::TICKS_W-1:0];
                bis_pkg::CFG_PRIMING:
                    r_cfg.priming_ticks <= i_cfg_data[bis_pkg::TICKS_W-1:0];
                bis_pkg::CFG_STOP_GLOW:
                    r_cfg.stop_glow_ticks <= i_cfg_data[bis_pkg::TICKS_W-1:0];
                bis_pkg::CFG_COOLDOWN:
                    r_cfg.cooldown_ticks <= i_cfg_data[bis_pkg::TICKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/bis_seq_core.sv -----
module bis_seq_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  bis_pkg::t_item   i_item,
    input  bis_pkg::t_cfg    i_cfg,
    output bis_pkg::t_status o_status
);

    bis_pkg::t_phase                   r_phase, n_phase;
    logic [bis_pkg::TICKS_W-1:0]       r_count, n_count;
    logic                              r_fan_on, n_fan_on;
    logic [bis_pkg::LEVEL_W-1:0]       r_fan_level, n_fan_level;
    logic                              r_pump_on, n_pump_on;
    logic [bis_pkg::LEVEL_W-1:0]       r_pump_rate, n_pump_rate;
    logic                              r_glow, n_glow;
    logic [bis_pkg::STEP_W-1:0]        r_step, n_step;
    logic [bis_pkg::LEVEL_W-1:0]       r_fan_tab  [bis_pkg::NUM_STEPS];
    logic [bis_pkg::LEVEL_W-1:0]       r_pump_tab [bis_pkg::NUM_STEPS];
    logic                              timed;
    logic                              tab_we;

    assign timed = (r_phase == bis_pkg::PH_PREHEAT) || (r_phase == bis_pkg::PH_PRIMING) ||
                   (r_phase == bis_pkg::PH_STOPGLOW) || (r_phase == bis_pkg::PH_COOLING);

    assign tab_we = i_fire && (i_item.op == bis_pkg::OP_LOAD) &&
                    bis_pkg::step_ok(i_item.step_index);

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_fan_on    = r_fan_on;
        n_fan_level = r_fan_level;
        n_pump_on   = r_pump_on;
        n_pump_rate = r_pump_rate;
        n_glow      = r_glow;
        n_step      = r_step;
        case (i_item.op)
            bis_pkg::OP_TICK: begin
                if (timed) begin
                    if (r_count > bis_pkg::TICKS_W'(1)) begin
                        n_count = r_count - bis_pkg::TICKS_W'(1);
                    end else begin
                        n_count = '0;
                        case (r_phase)
                            bis_pkg::PH_PREHEAT: begin
                                n_pump_on   = 1'b1;
                                n_pump_rate = i_cfg.startup_pump_rate;
                                n_count     = bis_pkg::timer_load(i_cfg.priming_ticks);
                                n_phase     = bis_pkg::PH_PRIMING;
                            end
                            bis_pkg::PH_PRIMING: begin
                                // Running always starts at power step 0.
                                n_glow      = 1'b0;
                                n_fan_level = r_fan_tab[bis_pkg::STEP_W'(0)];
                                n_pump_rate = r_pump_tab[bis_pkg::STEP_W'(0)];
                                n_step      = '0;
                                n_phase     = bis_pkg::PH_RUNNING;
                            end
                            bis_pkg::PH_STOPGLOW: begin
                                n_glow  = 1'b0;
                                n_count = bis_pkg::timer_load(i_cfg.cooldown_ticks);
                                n_phase = bis_pkg::PH_COOLING;
                            end
                            bis_pkg::PH_COOLING: begin
                                n_fan_on = 1'b0;
                                n_phase  = bis_pkg::PH_OFF;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            bis_pkg::OP_START: begin
                if (r_phase == bis_pkg::PH_OFF) begin
                    n_fan_on    = 1'b1;
                    n_fan_level = i_cfg.ignite_fan_level;
                    n_glow      = 1'b1;
                    n_count     = bis_pkg::timer_load(i_cfg.preheat_ticks);
                    n_phase     = bis_pkg::PH_PREHEAT;
                end
            end
            bis_pkg::OP_STOP: begin
                if (r_phase == bis_pkg::PH_RUNNING) begin
                    n_fan_level = i_cfg.shutdown_fan_level;
                    n_pump_on   = 1'b0;
                    n_glow      = 1'b1;
                    n_count     = bis_pkg::timer_load(i_cfg.stop_glow_ticks);
                    n_phase     = bis_pkg::PH_STOPGLOW;
                end
            end
            bis_pkg::OP_SELECT: begin
                if (bis_pkg::step_ok(i_item.step_index)) begin
                    n_fan_level = r_fan_tab[i_item.step_index];
                    n_pump_rate = r_pump_tab[i_item.step_index];
                    n_step      = i_item.step_index;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= bis_pkg::PH_OFF;
            r_count     <= '0;
            r_fan_on    <= 1'b0;
            r_fan_level <= '0;
            r_pump_on   <= 1'b0;
            r_pump_rate <= '0;
            r_glow      <= 1'b0;
            r_step      <= '0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_fan_on    <= n_fan_on;
            r_fan_level <= n_fan_level;
            r_pump_on   <= n_pump_on;
            r_pump_rate <= n_pump_rate;
            r_glow      <= n_glow;
            r_step      <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fan_tab  <= '{default: '0};
            r_pump_tab <= '{default: '0};
        end else if (tab_we) begin
            r_fan_tab[i_item.step_index]  <= i_item.entry_fan_power;
            r_pump_tab[i_item.step_index] <= i_item.entry_pump_rate;
        end
    end

    assign o_status.phase         = bis_pkg::phase_code(r_phase);
    assign o_status.fan_running   = r_fan_on;
    assign o_status.fan_level     = r_fan_level;
    assign o_status.pump_running  = r_pump_on;
    assign o_status.pump_rate     = r_pump_rate;
    assign o_status.glow_plug_lit = r_glow;
    assign o_status.current_step  = r_step;

`ifndef ASSERT_OFF
    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_phase))
        else $error("phase register lost its one-hot code");

    a_glow_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_glow == ((r_phase == bis_pkg::PH_PREHEAT) || (r_phase == bis_pkg::PH_PRIMING) ||
                   (r_phase == bis_pkg::PH_STOPGLOW)))
        else $error("glow plug state disagrees with phase");

    a_pump_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pump_on == ((r_phase == bis_pkg::PH_PRIMING) || (r_phase == bis_pkg::PH_RUNNING)))
        else $error("pump enable disagrees with phase");

    a_fan_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fan_on == (r_phase != bis_pkg::PH_OFF))
        else $error("fan enable disagrees with phase");

    a_count_timed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) == timed)
        else $error("countdown is running outside a timed phase");
`endif

endmodule

// ----- hdl/burner_ignition_sequencer_top.sv -----
// Burner ignition sequencer.
// Input channel: i_in_valid / o_in_stall carry one beat of op, step_index,
// entry_fan_power and entry_pump_rate. Output channel: o_out_valid /
// i_out_stall carry one status beat per input beat, in order: phase, fan and
// pump enables and levels, glow plug and the current power step, all taken
// after the input beat has been applied.
// A status beat passes through the input register, then the state update that
// also forms the output register. Throughput is one beat per cycle while the
// receiver does not stall; the state update is the only loop. When the
// receiver stalls, the status beat holds and an empty input register still
// takes one more beat; o_in_stall is high while a beat waits in the input
// register behind a stalled status beat. Configuration registers are written
// through i_cfg_we, i_cfg_index and i_cfg_data; the user must write them only
// while the block is idle, which the block itself does not enforce. Reset
// (synchronous, active low) puts the burner off, clears the power step table
// and loads the default durations and levels; no beat is held after reset.
module burner_ignition_sequencer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bis_pkg::OP_W-1:0]       i_op,
    input  logic [bis_pkg::STEP_W-1:0]     i_step_index,
    input  logic [bis_pkg::LEVEL_W-1:0]    i_entry_fan_power,
    input  logic [bis_pkg::LEVEL_W-1:0]    i_entry_pump_rate,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bis_pkg::PHASE_W-1:0]    o_phase,
    output logic                           o_fan_running,
    output logic [bis_pkg::LEVEL_W-1:0]    o_fan_level,
    output logic                           o_pump_running,
    output logic [bis_pkg::LEVEL_W-1:0]    o_pump_rate,
    output logic                           o_glow_plug_lit,
    output logic [bis_pkg::STEP_W-1:0]     o_current_step
);

    logic             r_in_valid;
    bis_pkg::t_item   r_item;
    logic             r_out_valid;
    logic             out_free;
    logic             fire;
    logic             in_take;
    bis_pkg::t_cfg    cfg;
    bis_pkg::t_status status;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.op              <= i_op;
            r_item.step_index      <= i_step_index;
            r_item.entry_fan_power <= i_entry_fan_power;
            r_item.entry_pump_rate <= i_entry_pump_rate;
        end
    end

    bis_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bis_seq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_status (status)
    );

    assign o_out_valid     = r_out_valid;
    assign o_phase         = status.phase;
    assign o_fan_running   = status.fan_running;
    assign o_fan_level     = status.fan_level;
    assign o_pump_running  = status.pump_running;
    assign o_pump_rate     = status.pump_rate;
    assign o_glow_plug_lit = status.glow_plug_lit;
    assign o_current_step  = status.current_step;

endmodule

// ----- tb/burner_ignition_sequencer_top_tb.sv -----
`timescale 1ns / 1ps

module burner_ignition_sequencer_top_tb;
    import bis_pkg::*;

    localparam logic [OP_W-1:0]      OP_UNUSED_LO = 3'd5;
    localparam logic [OP_W-1:0]      OP_UNUSED_HI = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;
    localparam int                   NUM_REG_SLOTS = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_op = OP_TICK;
    logic [STEP_W-1:0]     i_step_index = '0;
    logic [LEVEL_W-1:0]    i_entry_fan_power = '0;
    logic [LEVEL_W-1:0]    i_entry_pump_rate = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [PHASE_W-1:0]    o_phase;
    logic                  o_fan_running;
    logic [LEVEL_W-1:0]    o_fan_level;
    logic                  o_pump_running;
    logic [LEVEL_W-1:0]    o_pump_rate;
    logic                  o_glow_plug_lit;
    logic [STEP_W-1:0]     o_current_step;

    burner_ignition_sequencer_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_op              (i_op),
        .i_step_index      (i_step_index),
        .i_entry_fan_power (i_entry_fan_power),
        .i_entry_pump_rate (i_entry_pump_rate),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_phase           (o_phase),
        .o_fan_running     (o_fan_running),
        .o_fan_level       (o_fan_level),
        .o_pump_running    (o_pump_running),
        .o_pump_rate       (o_pump_rate),
        .o_glow_plug_lit   (o_glow_plug_lit),
        .o_current_step    (o_current_step)
    );

    always #5 i_clk = ~i_clk;

    // Local copy of the heater settings and state.
    logic [LEVEL_W-1:0] cfg_start_fan;
    logic [LEVEL_W-1:0] cfg_stop_fan;
    logic [LEVEL_W-1:0] cfg_start_pump;
    logic [TICKS_W-1:0] cfg_preheat;
    logic [TICKS_W-1:0] cfg_priming;
    logic [TICKS_W-1:0] cfg_stop_glow;
    logic [TICKS_W-1:0] cfg_cooldown;

    logic [PHASE_W-1:0] heat_phase;
    logic [TICKS_W-1:0] ticks_left;
    logic               fan_on;
    logic [LEVEL_W-1:0] fan_level;
    logic               pump_on;
    logic [LEVEL_W-1:0] pump_rate;
    logic               glow_on;
    logic [STEP_W-1:0]  active_step;
    logic [LEVEL_W-1:0] fan_table [NUM_STEPS];
    logic [LEVEL_W-1:0] pump_table [NUM_STEPS];

    t_status status_q [$];
    int      error_count = 0;
    bit      send_gaps = 1'b1;
    bit      recv_stalls = 1'b1;

    function automatic logic [TICKS_W-1:0] ticks_or_one(input logic [TICKS_W-1:0] ticks);
        return (ticks == '0) ? TICKS_W'(1) : ticks;
    endfunction

    function automatic void select_step(input logic [STEP_W-1:0] idx);
        if (int'(idx) < NUM_STEPS) begin
            fan_level   = fan_table[idx];
            pump_rate   = pump_table[idx];
            active_step = idx;
        end
    endfunction

    function automatic void end_timed_phase();
        case (heat_phase)
            CODE_PREHEAT: begin
                pump_on    = 1'b1;
                pump_rate  = cfg_start_pump;
                ticks_left = ticks_or_one(cfg_priming);
                heat_phase = CODE_PRIMING;
            end
            CODE_PRIMING: begin
                glow_on = 1'b0;
                select_step('0);
                ticks_left = '0;
                heat_phase = CODE_RUNNING;
            end
            CODE_STOPGLOW: begin
                glow_on    = 1'b0;
                ticks_left = ticks_or_one(cfg_cooldown);
                heat_phase = CODE_COOLING;
            end
            CODE_COOLING: begin
                fan_on     = 1'b0;
                ticks_left = '0;
                heat_phase = CODE_OFF;
            end
            default: begin
            end
        endcase
    endfunction

    // Applies one beat to the local state and returns the status it leads to.
    function automatic t_status advance_heater(input t_item beat);
        t_status st;
        case (beat.op)
            OP_TICK: begin
                if (heat_phase == CODE_PREHEAT || heat_phase == CODE_PRIMING ||
                    heat_phase == CODE_STOPGLOW || heat_phase == CODE_COOLING) begin
                    if (ticks_left <= TICKS_W'(1)) begin
                        ticks_left = '0;
                        end_timed_phase();
                    end else begin
                        ticks_left = ticks_left - 1'b1;
                    end
                end
            end
            OP_START: begin
                if (heat_phase == CODE_OFF) begin
                    fan_on     = 1'b1;
                    fan_level  = cfg_start_fan;
                    glow_on    = 1'b1;
                    ticks_left = ticks_or_one(cfg_preheat);
                    heat_phase = CODE_PREHEAT;
                end
            end
            OP_STOP: begin
                if (heat_phase == CODE_RUNNING) begin
                    fan_level  = cfg_stop_fan;
                    pump_on    = 1'b0;
                    glow_on    = 1'b1;
                    ticks_left = ticks_or_one(cfg_stop_glow);
                    heat_phase = CODE_STOPGLOW;
                end
            end
            OP_SELECT: select_step(beat.step_index);
            OP_LOAD: begin
                if (int'(beat.step_index) < NUM_STEPS) begin
                    fan_table[beat.step_index]  = beat.entry_fan_power;
                    pump_table[beat.step_index] = beat.entry_pump_rate;
                end
            end
            default: begin
            end
        endcase
        st.phase         = heat_phase;
        st.fan_running   = fan_on;
        st.fan_level     = fan_level;
        st.pump_running  = pump_on;
        st.pump_rate     = pump_rate;
        st.glow_plug_lit = glow_on;
        st.current_step  = active_step;
        return st;
    endfunction

    task automatic send_beat(input logic [OP_W-1:0] op, input logic [STEP_W-1:0] idx,
                             input logic [LEVEL_W-1:0] fan, input logic [LEVEL_W-1:0] pump);
        t_item beat;
        beat.op              = op;
        beat.step_index      = idx;
        beat.entry_fan_power = fan;
        beat.entry_pump_rate = pump;
        if (send_gaps) begin
            while ($urandom_range(99) < 6) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid        <= 1'b1;
        i_op              <= op;
        i_step_index      <= idx;
        i_entry_fan_power <= fan;
        i_entry_pump_rate <= pump;
        do @(posedge i_clk); while (o_in_stall);
        // Valid stays high here; the next beat or a drain decides what follows.
        status_q.push_back(advance_heater(beat));
    endtask

    task automatic wait_settled();
        i_in_valid <= 1'b0;
        while (status_q.size() != 0) @(posedge i_clk);
    endtask

    // Writes all register slots, the unused one included, then drops the enable.
    task automatic write_settings(input logic [CFG_DATA_W-1:0] start_fan,
                                  input logic [CFG_DATA_W-1:0] stop_fan,
                                  input logic [CFG_DATA_W-1:0] start_pump,
                                  input logic [CFG_DATA_W-1:0] preheat,
                                  input logic [CFG_DATA_W-1:0] priming,
                                  input logic [CFG_DATA_W-1:0] stop_glow,
                                  input logic [CFG_DATA_W-1:0] cooldown);
        logic [CFG_DATA_W-1:0] vals [NUM_REG_SLOTS];
        logic [CFG_IDX_W-1:0]  idx;
        vals[CFG_STARTUP_FAN]  = start_fan;
        vals[CFG_STOP_FAN]     = stop_fan;
        vals[CFG_STARTUP_PUMP] = start_pump;
        vals[CFG_PREHEAT]      = preheat;
        vals[CFG_PRIMING]      = priming;
        vals[CFG_STOP_GLOW]    = stop_glow;
        vals[CFG_COOLDOWN]     = cooldown;
        vals[CFG_UNUSED]       = CFG_DATA_W'($urandom);
        i_cfg_we <= 1'b1;
        for (int k = 0; k < NUM_REG_SLOTS; k++) begin
            idx = CFG_IDX_W'(k);
            i_cfg_index <= idx;
            i_cfg_data  <= vals[idx];
            @(posedge i_clk);
            case (idx)
                CFG_STARTUP_FAN:  cfg_start_fan  = vals[idx][LEVEL_W-1:0];
                CFG_STOP_FAN:     cfg_stop_fan   = vals[idx][LEVEL_W-1:0];
                CFG_STARTUP_PUMP: cfg_start_pump = vals[idx][LEVEL_W-1:0];
                CFG_PREHEAT:      cfg_preheat    = vals[idx][TICKS_W-1:0];
                CFG_PRIMING:      cfg_priming    = vals[idx][TICKS_W-1:0];
                CFG_STOP_GLOW:    cfg_stop_glow  = vals[idx][TICKS_W-1:0];
                CFG_COOLDOWN:     cfg_cooldown   = vals[idx][TICKS_W-1:0];
                default: begin
                end
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 50) return OP_TICK;
        if (r < 60) return OP_START;
        if (r < 70) return OP_STOP;
        if (r < 82) return OP_SELECT;
        if (r < 94) return OP_LOAD;
        return OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
    endfunction

    // Mostly a handful of ticks so that whole start/stop cycles fit in a round.
    function automatic logic [CFG_DATA_W-1:0] short_ticks();
        if ($urandom_range(99) < 10) return CFG_DATA_W'($urandom_range(40));
        return CFG_DATA_W'($urandom_range(6));
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= recv_stalls && ($urandom_range(99) < 6);
    end

    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_q.size() == 0) begin
                error_count++;
                $display("%0t: status beat expected none, got phase %0d", $time, o_phase);
            end else begin
                want = status_q.pop_front();
                check_field("phase", want.phase, o_phase);
                check_field("fan_running", want.fan_running, o_fan_running);
                check_field("fan_level", want.fan_level, o_fan_level);
                check_field("pump_running", want.pump_running, o_pump_running);
                check_field("pump_rate", want.pump_rate, o_pump_rate);
                check_field("glow_plug_lit", want.glow_plug_lit, o_glow_plug_lit);
                check_field("current_step", want.current_step, o_current_step);
            end
        end
    end

    // Power-up state while off: ticks and a stop change nothing, the table still works.
    task automatic test_power_up_idle();
        repeat (3) send_beat(OP_TICK, 3'($urandom), 8'($urandom), 8'($urandom));
        send_beat(OP_STOP, 3'($urandom), 8'($urandom), 8'($urandom));
        send_beat(OP_SELECT, 3'd4, 8'($urandom), 8'($urandom));
        send_beat(OP_LOAD, 3'd2, 8'($urandom), 8'($urandom));
        send_beat(OP_SELECT, 3'd2, 8'($urandom), 8'($urandom));
        send_beat(OP_TICK, 3'($urandom), 8'($urandom), 8'($urandom));
        send_beat(OP_SELECT, 3'd0, 8'($urandom), 8'($urandom));
    endtask

    task automatic test_directed_cases();
        wait_settled();
        // Upper data bits on the 8-bit registers must be dropped.
        write_settings(24'h5A00FF, 24'h000000, 24'hFF12AB, 24'd0, 24'd1, 24'd0, 24'd2);
        send_beat(OP_LOAD, 3'd7, 8'hFF, 8'hFF);
        send_beat(OP_LOAD, 3'd0, 8'h80, 8'h7F);
        send_beat(OP_SELECT, 3'd7, 8'h00, 8'h00);
        send_beat(OP_TICK, 3'd0, 8'h00, 8'h00);
        send_beat(OP_STOP, 3'd0, 8'h00, 8'h00);
        for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
            send_beat(OP_W'(op), 3'd5, 8'hFF, 8'hFF);
        send_beat(OP_START, 3'd0, 8'h00, 8'h00);
        send_beat(OP_START, 3'd0, 8'h00, 8'h00);
        send_beat(OP_TICK, 3'd0, 8'h00, 8'h00);
        send_beat(OP_SELECT, 3'd7, 8'h00, 8'h00);
        send_beat(OP_TICK, 3'd0, 8'h00, 8'h00);
        send_beat(OP_START, 3'd0, 8'h00, 8'h00);
        send_beat(OP_TICK, 3'd0, 8'h00, 8'h00);
        send_beat(OP_STOP, 3'd0, 8'h00, 8'h00);
        send_beat(OP_STOP, 3'd0, 8'h00, 8'h00);
        send_beat(OP_TICK, 3'd0, 8'h00, 8'h00);
        send_beat(OP_SELECT, 3'd0, 8'h00, 8'h00);
        send_beat(OP_TICK, 3'd0, 8'h00, 8'h00);
        send_beat(OP_TICK, 3'd0, 8'h00, 8'h00);
    endtask

    task automatic test_random_cycles();
        for (int round = 0; round < 6; round++) begin
            wait_settled();
            send_gaps   = (round != 2);
            recv_stalls = (round != 2);
            write_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                           CFG_DATA_W'($urandom), short_ticks(), short_ticks(),
                           short_ticks(), short_ticks());
            for (int n = 0; n < 300; n++) begin
                if (round == 4 && n == 150)
                    wait_settled();
                send_beat(pick_op(), 3'($urandom_range(7)), 8'($urandom), 8'($urandom));
            end
        end
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    // Longest durations: the burner stays in preheat for the rest of the run.
    task automatic test_longest_durations();
        wait_settled();
        write_settings('1, '1, '1, '1, '1, '1, '1);
        send_beat(OP_START, 3'd0, 8'h00, 8'h00);
        repeat (20) begin
            send_beat(OP_TICK, 3'($urandom), 8'($urandom), 8'($urandom));
            send_beat(pick_op(), 3'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        cfg_start_fan  = 8'd100;
        cfg_stop_fan   = 8'd100;
        cfg_start_pump = 8'd20;
        cfg_preheat    = 24'd60000;
        cfg_priming    = 24'd20000;
        cfg_stop_glow  = 24'd30000;
        cfg_cooldown   = 24'd60000;
        heat_phase     = CODE_OFF;
        ticks_left     = '0;
        fan_on         = 1'b0;
        fan_level      = '0;
        pump_on        = 1'b0;
        pump_rate      = '0;
        glow_on        = 1'b0;
        active_step    = '0;
        fan_table      = '{default: '0};
        pump_table     = '{default: '0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_power_up_idle();
        test_directed_cases();
        test_random_cycles();
        test_longest_durations();

        wait_settled();
        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
